### rtl/core/ple_pkg.sv
// Package with shared constants, payload types and command/status structs.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int FUNC_W   = 2;
  localparam int LOC_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > LOC_W) ? CNT_W : LOC_W;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [LOC_W-1:0]         location;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
  } out_t;

  typedef enum logic [1:0] {
    RD_IDX_DN,
    RD_IDX_UP,
    RD_POS
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT,
    WR_PLACE
  } wr_sel_t;

  typedef struct packed {
    logic              load;
    logic              idx_ld_cnt;
    logic              idx_ld_pos;
    logic              idx_inc;
    logic              idx_dec;
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic              wr_en;
    wr_sel_t           wr_sel;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic              out_use_rd;
  } ple_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ins_range;
    logic              full;
    logic              pos_lt_cnt;
    logic              ins_more;
    logic              del_more;
  } ple_sts_t;

endpackage

### rtl/core/ple_datapath.sv
// Datapath: entry memory, entry count, shift index and result register.
`timescale 1ns / 1ps

module ple_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ple_pkg::in_t       in_data,
  input  ple_pkg::ple_cmd_t  cmd,
  output ple_pkg::ple_sts_t  sts,
  output ple_pkg::out_t      out_data
);

  logic signed [ple_pkg::DATA_W-1:0] mem [ple_pkg::CAPACITY];

  ple_pkg::in_t                      item_r;
  logic [ple_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ple_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic signed [ple_pkg::DATA_W-1:0] rd_data_r;
  ple_pkg::out_t                     out_r;

  logic [ple_pkg::CMP_W-1:0]         pos_x, cnt_x, idx_x;
  logic [ple_pkg::CNT_W:0]           idx_up;
  logic [ple_pkg::CNT_W-1:0]         idx_dn;
  logic [ple_pkg::ADDR_W-1:0]        rd_addr, wr_addr;
  logic signed [ple_pkg::DATA_W-1:0] wr_data;

  assign pos_x  = ple_pkg::CMP_W'(item_r.location);
  assign cnt_x  = ple_pkg::CMP_W'(cnt_r);
  assign idx_x  = ple_pkg::CMP_W'(idx_r);
  assign idx_up = {1'b0, idx_r} + 1'b1;
  assign idx_dn = idx_r - 1'b1;

  assign sts.func       = item_r.func;
  assign sts.ins_range  = pos_x > cnt_x;
  assign sts.full       = cnt_r == ple_pkg::CNT_W'(ple_pkg::CAPACITY);
  assign sts.pos_lt_cnt = pos_x < cnt_x;
  assign sts.ins_more   = idx_x > pos_x;
  assign sts.del_more   = idx_up < {1'b0, cnt_r};

  always_comb begin
    case (cmd.rd_sel)
      ple_pkg::RD_IDX_DN: rd_addr = idx_dn[ple_pkg::ADDR_W-1:0];
      ple_pkg::RD_IDX_UP: rd_addr = idx_up[ple_pkg::ADDR_W-1:0];
      ple_pkg::RD_POS:    rd_addr = pos_x[ple_pkg::ADDR_W-1:0];
      default:            rd_addr = pos_x[ple_pkg::ADDR_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      ple_pkg::WR_SHIFT: begin
        wr_addr = idx_r[ple_pkg::ADDR_W-1:0];
        wr_data = rd_data_r;
      end
      ple_pkg::WR_PLACE: begin
        wr_addr = pos_x[ple_pkg::ADDR_W-1:0];
        wr_data = item_r.value;
      end
      default: begin
        wr_addr = idx_r[ple_pkg::ADDR_W-1:0];
        wr_data = rd_data_r;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_ld_cnt) begin
      idx_nxt = cnt_r;
    end else if (cmd.idx_ld_pos) begin
      idx_nxt = pos_x[ple_pkg::CNT_W-1:0];
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_up[ple_pkg::CNT_W-1:0];
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r.status     <= cmd.out_status;
      out_r.read_value <= cmd.out_use_rd ? rd_data_r : '0;
      out_r.count      <= ple_pkg::COUNT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_data = out_r;

endmodule

### rtl/core/ple_ctrl.sv
// Controller: sequences check, shift, read and result hand-off per transaction.
`timescale 1ns / 1ps

module ple_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ple_pkg::ple_sts_t  sts,
  output ple_pkg::ple_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_TEST,
    S_INS_WR,
    S_DEL_TEST,
    S_DEL_WR,
    S_GET_WAIT,
    S_FINISH
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ple_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic                      use_rd_r, use_rd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = ple_pkg::RD_POS;
    cmd.wr_sel    = ple_pkg::WR_SHIFT;
    state_nxt     = state_r;
    stat_nxt      = stat_r;
    use_rd_nxt    = use_rd_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        use_rd_nxt = 1'b0;
        stat_nxt   = ple_pkg::STAT_RANGE;
        state_nxt  = S_FINISH;
        case (sts.func)
          ple_pkg::FUNC_INSERT: begin
            if (sts.ins_range) begin
              stat_nxt = ple_pkg::STAT_RANGE;
            end else if (sts.full) begin
              stat_nxt = ple_pkg::STAT_FULL;
            end else begin
              cmd.idx_ld_cnt = 1'b1;
              state_nxt      = S_INS_TEST;
            end
          end
          ple_pkg::FUNC_GET: begin
            if (sts.pos_lt_cnt) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ple_pkg::RD_POS;
              state_nxt  = S_GET_WAIT;
            end
          end
          ple_pkg::FUNC_DELETE: begin
            if (sts.pos_lt_cnt) begin
              cmd.idx_ld_pos = 1'b1;
              state_nxt      = S_DEL_TEST;
            end
          end
          default: begin
            stat_nxt = ple_pkg::STAT_RANGE;
          end
        endcase
      end
      S_INS_TEST: begin
        if (sts.ins_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ple_pkg::RD_IDX_DN;
          state_nxt  = S_INS_WR;
        end else begin
          // drop the new value into the opened slot
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = ple_pkg::WR_PLACE;
          cmd.cnt_inc = 1'b1;
          stat_nxt    = ple_pkg::STAT_OK;
          state_nxt   = S_FINISH;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ple_pkg::WR_SHIFT;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_INS_TEST;
      end
      S_DEL_TEST: begin
        if (sts.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ple_pkg::RD_IDX_UP;
          state_nxt  = S_DEL_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          stat_nxt    = ple_pkg::STAT_OK;
          state_nxt   = S_FINISH;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ple_pkg::WR_SHIFT;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_DEL_TEST;
      end
      S_GET_WAIT: begin
        stat_nxt   = ple_pkg::STAT_OK;
        use_rd_nxt = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = stat_r;
          cmd.out_use_rd = use_rd_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stat_r      <= ple_pkg::STAT_OK;
      use_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stat_r      <= stat_nxt;
      use_rd_r    <= use_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/positional_insert_delete_list.sv
// Insert and delete shift the entries between location and count one at a time, each move
// a read (INS_TEST/DEL_TEST) then a write (INS_WR/DEL_WR); get is a single read at location.
// One transaction at a time: the next can be accepted in the cycle after the result is registered.
// A result waiting under out_stall does not block the next transaction until its finish.
// Reset (rst_n low, synchronous) empties the list and clears out_valid; memory is not cleared.
`timescale 1ns / 1ps

module positional_insert_delete_list (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ple_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ple_pkg::out_t out_data
);

  ple_pkg::ple_cmd_t cmd;
  ple_pkg::ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ple_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

### verif/tb_positional_insert_delete_list.sv
// Self-checking testbench for the positional insert/delete list: directed table, then random ops.
`timescale 1ns / 1ps

module tb_positional_insert_delete_list;
  import ple_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam bit  FIXED_EXP   = 1'b1;
  localparam bit  PREDICTED   = 1'b0;
  localparam int  RANDOM_OPS  = 1400;
  localparam int  DRAIN_WAIT  = 200;
  localparam int  CYCLE_LIMIT = 1000000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // shadow copy of the list contents
  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int shadow_len;
  int deepest_len;

  out_t     pending_results [$];
  dir_row_t directed_rows [$];

  int error_count;
  int cycle_count;
  int sent_count;
  int checked_count;
  int ok_seen;
  int range_seen;
  int full_seen;
  int burst_left;
  stall_mode_t stall_mode;
  int stall_phase;

  positional_insert_delete_list uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Apply one operation to the shadow list and return the result it must produce.
  function automatic out_t apply_list_op(in_t op);
    out_t r;
    int   pos;
    int   k;
    pos          = int'(op.location);
    r.status     = STAT_RANGE;
    r.read_value = '0;
    case (op.func)
      FUNC_INSERT: begin
        if (pos > shadow_len) begin
          r.status = STAT_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (k = shadow_len; k > pos; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = op.value;
          shadow_len++;
          r.status = STAT_OK;
        end
      end
      FUNC_GET: begin
        if (pos < shadow_len) begin
          r.read_value = shadow_list[pos];
          r.status     = STAT_OK;
        end
      end
      FUNC_DELETE: begin
        if (pos < shadow_len) begin
          for (k = pos; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len--;
          r.status = STAT_OK;
        end
      end
      default: ;
    endcase
    r.count = shadow_len[COUNT_W-1:0];
    if (shadow_len > deepest_len) deepest_len = shadow_len;
    return r;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] f, input int loc, input logic [DATA_W-1:0] v,
                         input bit fixed, input logic [STAT_W-1:0] st,
                         input logic [DATA_W-1:0] rv, input int cnt);
    dir_row_t row;
    row.item.func       = f;
    row.item.location   = LOC_W'(loc);
    row.item.value      = v;
    row.fixed           = fixed;
    row.want.status     = st;
    row.want.read_value = rv;
    row.want.count      = COUNT_W'(cnt);
    directed_rows.push_back(row);
  endtask

  // Random operation shaped by phase: mixed, fill, read-heavy, drain; plus noise and bad positions.
  function automatic in_t pick_op(int idx);
    in_t it;
    int  phase;
    int  roll;
    int  ins_w;
    int  get_w;
    int  lo;
    phase = (idx / 150) % 4;
    roll  = $urandom_range(0, 9);
    case (roll)
      0:       it.value = 32'sh7fffffff;
      1:       it.value = 32'sh80000000;
      2:       it.value = '0;
      3:       it.value = '1;
      default: it.value = $urandom;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      it.func     = FUNC_W'($urandom_range(0, 3));
      it.location = LOC_W'($urandom_range(0, 127));
    end else if (roll < 14) begin
      it.func     = FUNC_W'($urandom_range(0, 2));
      lo          = shadow_len + ((it.func == FUNC_INSERT) ? 1 : 0);
      it.location = LOC_W'($urandom_range(lo, 127));
    end else begin
      case (phase)
        0:       begin ins_w = 40; get_w = 30; end
        1:       begin ins_w = 85; get_w = 10; end
        2:       begin ins_w = 20; get_w = 60; end
        default: begin ins_w = 5;  get_w = 15; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_w || shadow_len == 0) it.func = FUNC_INSERT;
      else if (roll < ins_w + get_w) it.func = FUNC_GET;
      else it.func = FUNC_DELETE;
      roll = $urandom_range(0, 3);
      if (it.func == FUNC_INSERT) begin
        if (roll == 0) it.location = '0;
        else if (roll == 1) it.location = LOC_W'(shadow_len);
        else it.location = LOC_W'($urandom_range(0, shadow_len));
      end else begin
        if (roll == 0) it.location = '0;
        else if (roll == 1) it.location = LOC_W'(shadow_len - 1);
        else it.location = LOC_W'($urandom_range(0, shadow_len - 1));
      end
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is accepted.
  task automatic send_op(input in_t item, input bit fixed, input out_t want);
    int   gap;
    out_t predicted;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_op(item);
    pending_results.push_back(fixed ? want : predicted);
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver back-pressure pattern in one of four modes, re-picked at random as stall_phase advances.
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 97 == 0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= ((stall_phase % 5) < 2);
      default:        out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no pending expectation");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %0h, actual %0h", want.read_value, out_data.read_value);
          error_count++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_data.count);
          error_count++;
        end
        case (out_data.status)
          STAT_OK:    ok_seen++;
          STAT_RANGE: range_seen++;
          STAT_FULL:  full_seen++;
          default:    ;
        endcase
      end
    end
  end

  initial begin
    int   i;
    int   directed_count;
    in_t  item;
    out_t none;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    rst_n         = 1'b0;
    shadow_len    = 0;
    deepest_len   = 0;
    error_count   = 0;
    cycle_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    ok_seen       = 0;
    range_seen    = 0;
    full_seen     = 0;
    burst_left    = 0;
    stall_mode    = STALL_NONE;
    stall_phase   = 0;
    none          = '0;

    // Empty list, bad positions, unused selector, extremes of value and position, shifting insert/delete.
    add_row(FUNC_GET,    0,   32'h0,        FIXED_EXP, STAT_RANGE, 32'h0,        0);
    add_row(FUNC_DELETE, 0,   32'h0,        FIXED_EXP, STAT_RANGE, 32'h0,        0);
    add_row(FUNC_INSERT, 1,   32'h5,        FIXED_EXP, STAT_RANGE, 32'h0,        0);
    add_row(FUNC_UNUSED, 0,   32'h0,        FIXED_EXP, STAT_RANGE, 32'h0,        0);
    add_row(FUNC_INSERT, 0,   32'h7fffffff, FIXED_EXP, STAT_OK,    32'h0,        1);
    add_row(FUNC_INSERT, 0,   32'h80000000, FIXED_EXP, STAT_OK,    32'h0,        2);
    add_row(FUNC_GET,    0,   32'h0,        FIXED_EXP, STAT_OK,    32'h80000000, 2);
    add_row(FUNC_GET,    1,   32'h0,        FIXED_EXP, STAT_OK,    32'h7fffffff, 2);
    add_row(FUNC_GET,    2,   32'h0,        FIXED_EXP, STAT_RANGE, 32'h0,        2);
    add_row(FUNC_INSERT, 2,   32'hffffffff, FIXED_EXP, STAT_OK,    32'h0,        3);
    add_row(FUNC_INSERT, 1,   32'h0,        PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_GET,    127, 32'hffffffff, FIXED_EXP, STAT_RANGE, 32'h0,        4);
    add_row(FUNC_DELETE, 127, 32'h0,        FIXED_EXP, STAT_RANGE, 32'h0,        4);
    add_row(FUNC_INSERT, 127, 32'h1,        FIXED_EXP, STAT_RANGE, 32'h0,        4);
    add_row(FUNC_INSERT, 5,   32'h1,        FIXED_EXP, STAT_RANGE, 32'h0,        4);
    add_row(FUNC_DELETE, 4,   32'h0,        FIXED_EXP, STAT_RANGE, 32'h0,        4);
    add_row(FUNC_GET,    3,   32'h55555555, PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_DELETE, 0,   32'h0,        PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_GET,    0,   32'h0,        PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_DELETE, 2,   32'h0,        PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_GET,    1,   32'h0,        PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_UNUSED, 127, 32'haaaaaaaa, FIXED_EXP, STAT_RANGE, 32'h0,        2);
    add_row(FUNC_DELETE, 1,   32'h0,        PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_DELETE, 0,   32'h0,        PREDICTED, STAT_OK,    32'h0,        0);
    add_row(FUNC_GET,    0,   32'h0,        FIXED_EXP, STAT_RANGE, 32'h0,        0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) send_op(directed_rows[r].item, directed_rows[r].fixed,
                                       directed_rows[r].want);
    directed_count = sent_count;

    for (i = 0; i < RANDOM_OPS; i++) begin
      item = pick_op(i);
      send_op(item, PREDICTED, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d transactions (%0d from the directed table), %0d results checked",
             sent_count, directed_count, checked_count);
    $display("Statuses: ok %0d, out of range %0d, full %0d; list reached %0d entries",
             ok_seen, range_seen, full_seen, deepest_len);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
